// ===== design/iorc_pkg.sv =====
// shared types and constants for the interval overlap removal counter
package iorc_pkg;

  localparam int unsigned MAX_INTERVALS = 1024;
  localparam int unsigned COUNT_W = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic signed [31:0] start_point;
    logic signed [31:0] end_point;
    logic               final_item;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] removed_count;
    logic               set_overflowed;
  } out_item_t;

  typedef enum logic [2:0] {
    RD_I    = 3'd0,
    RD_IM1  = 3'd1,
    RD_JM2  = 3'd2,
    RD_I1   = 3'd3,
    RD_ZERO = 3'd4
  } rd_sel_e;

  typedef struct packed {
    logic    store;
    logic    clear;
    logic    i_set1;
    logic    key_load;
    logic    shift;
    logic    place;
    logic    cur_load;
    logic    scan_step;
    logic    removed_clr;
    rd_sel_e rd_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic i_ge_n;
    logic i1_ge_n;
    logic j_is1;
    logic gt;
    logic n_zero;
  } dp_status_t;

endpackage

// ===== design/iorc_dp.sv =====
// datapath: interval memory, sort and scan registers
module iorc_dp #(
  parameter int unsigned MaxIntervals = iorc_pkg::MAX_INTERVALS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  iorc_pkg::in_item_t   in_data_i,
  input  iorc_pkg::dp_cmd_t    cmd_i,
  output iorc_pkg::dp_status_t status_o,
  output iorc_pkg::out_item_t  out_data_o
);
  import iorc_pkg::*;

  localparam int unsigned AW = $clog2(MaxIntervals);
  localparam int unsigned CW = $clog2(MaxIntervals + 1);

  logic [63:0]   mem [MaxIntervals];
  logic [63:0]   rd_q, key_q, cur_q;
  logic [CW-1:0] count_q, count_d, i_q, i_d, j_q, j_d, removed_q, removed_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] raddr, waddr;
  logic [63:0]   wdata;
  logic          we;
  logic [31:0]   lo, hi;
  logic [CW:0]   i_plus1;
  logic          has_room;

  assign lo       = rd_q[63:32];
  assign hi       = rd_q[31:0];
  assign i_plus1  = {1'b0, i_q} + 1'b1;
  assign has_room = count_q < CW'(MaxIntervals);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_I:    raddr = i_q;
      RD_IM1:  raddr = i_q - 1'b1;
      RD_JM2:  raddr = j_q - CW'(2);
      RD_I1:   raddr = i_plus1[CW-1:0];
      default: raddr = '0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = count_q;
    wdata = {~in_data_i.start_point[31], in_data_i.start_point[30:0],
             ~in_data_i.end_point[31], in_data_i.end_point[30:0]};
    if (cmd_i.store && has_room) begin
      we = 1'b1;
    end else if (cmd_i.shift) begin
      we    = 1'b1;
      waddr = j_q;
      wdata = rd_q;
    end else if (cmd_i.place) begin
      we    = 1'b1;
      waddr = j_q;
      wdata = key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
    rd_q <= mem[raddr[AW-1:0]];
  end

  always_comb begin
    count_d   = count_q;
    ovf_d     = ovf_q;
    i_d       = i_q;
    j_d       = j_q;
    removed_d = removed_q;
    if (cmd_i.store) begin
      if (has_room) begin
        count_d = count_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.clear) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end
    if (cmd_i.i_set1) begin
      i_d = CW'(1);
    end
    if (cmd_i.key_load) begin
      j_d = i_q;
    end
    if (cmd_i.shift) begin
      j_d = j_q - 1'b1;
    end
    if (cmd_i.place || cmd_i.scan_step) begin
      i_d = i_plus1[CW-1:0];
    end
    if (cmd_i.removed_clr) begin
      removed_d = '0;
    end
    if (cmd_i.scan_step && ((lo == cur_q[63:32]) || (lo < cur_q[31:0]))) begin
      removed_d = removed_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      ovf_q     <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      removed_q <= '0;
    end else begin
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      i_q       <= i_d;
      j_q       <= j_d;
      removed_q <= removed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_load) begin
      key_q <= rd_q;
    end
    if (cmd_i.cur_load) begin
      cur_q <= rd_q;
    end else if (cmd_i.scan_step && (lo != cur_q[63:32])) begin
      if (lo >= cur_q[31:0] || cur_q[31:0] > hi) begin
        cur_q <= rd_q;
      end
    end
  end

  assign status_o.i_ge_n  = i_q >= count_q;
  assign status_o.i1_ge_n = i_plus1 >= {1'b0, count_q};
  assign status_o.j_is1   = j_q == CW'(1);
  assign status_o.gt      = rd_q > key_q;
  assign status_o.n_zero  = count_q == '0;

  assign out_data_o.removed_count  = (32'(removed_q) > 32'(COUNT_MAX)) ? COUNT_MAX
                                                                       : COUNT_W'(removed_q);
  assign out_data_o.set_overflowed = ovf_q;

endmodule

// ===== design/iorc_ctrl.sv =====
// controller: load, insertion sort, greedy scan and result hand-off
module iorc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 final_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  iorc_pkg::dp_status_t status_i,
  output iorc_pkg::dp_cmd_t    cmd_o
);
  import iorc_pkg::*;

  typedef enum logic [7:0] {
    S_LOAD       = 8'b0000_0001,
    S_SORT_CHK   = 8'b0000_0010,
    S_KEY        = 8'b0000_0100,
    S_CMP        = 8'b0000_1000,
    S_PLACE      = 8'b0001_0000,
    S_SCAN_INIT  = 8'b0010_0000,
    S_SCAN_FIRST = 8'b0100_0000,
    S_SCAN       = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    done_d  = done_q;
    cmd_o   = '0;
    cmd_o.rd_sel = RD_I;
    case (state_q)
      S_LOAD: begin
        if (done_q) begin
          if (out_ready_i) begin
            cmd_o.clear = 1'b1;
            done_d      = 1'b0;
          end
        end else if (in_valid_i) begin
          cmd_o.store = 1'b1;
          if (final_item_i) begin
            cmd_o.i_set1 = 1'b1;
            state_d      = S_SORT_CHK;
          end
        end
      end
      S_SORT_CHK: begin
        if (status_i.i_ge_n) begin
          state_d = S_SCAN_INIT;
        end else begin
          cmd_o.rd_sel = RD_I;
          state_d      = S_KEY;
        end
      end
      S_KEY: begin
        cmd_o.key_load = 1'b1;
        cmd_o.rd_sel   = RD_IM1;
        state_d        = S_CMP;
      end
      S_CMP: begin
        if (status_i.gt) begin
          cmd_o.shift = 1'b1;
          if (status_i.j_is1) begin
            state_d = S_PLACE;
          end else begin
            cmd_o.rd_sel = RD_JM2;
          end
        end else begin
          cmd_o.place = 1'b1;
          state_d     = S_SORT_CHK;
        end
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        state_d     = S_SORT_CHK;
      end
      S_SCAN_INIT: begin
        cmd_o.removed_clr = 1'b1;
        if (status_i.n_zero) begin
          done_d  = 1'b1;
          state_d = S_LOAD;
        end else begin
          cmd_o.rd_sel = RD_ZERO;
          cmd_o.i_set1 = 1'b1;
          state_d      = S_SCAN_FIRST;
        end
      end
      S_SCAN_FIRST: begin
        cmd_o.cur_load = 1'b1;
        if (status_i.i_ge_n) begin
          done_d  = 1'b1;
          state_d = S_LOAD;
        end else begin
          cmd_o.rd_sel = RD_I;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.i1_ge_n) begin
          done_d  = 1'b1;
          state_d = S_LOAD;
        end else begin
          cmd_o.rd_sel = RD_I1;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign in_ready_o  = (state_q == S_LOAD) && !done_q;
  assign out_valid_o = (state_q == S_LOAD) && done_q;

endmodule

// ===== design/interval_overlap_removal_count.sv =====
// top level: minimum interval removals over a loaded set
// loading takes one transaction per cycle into an interval memory with one write and one read port
// after the final transaction an insertion sort orders the n stored intervals, with a check,
// key load and compare per interval and at most n*(n-1)/2 shifts in total
// the scan then walks the sorted intervals; the result then waits for out_ready_i
// no input is taken from the final transaction until the result transaction completes
// reset clears the count, overflow flag and controller; memory contents are not cleared
module interval_overlap_removal_count #(
  parameter int unsigned MaxIntervals = iorc_pkg::MAX_INTERVALS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  iorc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output iorc_pkg::out_item_t out_data_o
);
  import iorc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  iorc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .final_item_i (in_data_i.final_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  iorc_dp #(
    .MaxIntervals (MaxIntervals)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input ready while a result is pending");

  a_ready_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> in_ready_o && !out_valid_o)
    else $error("block not ready after result transaction");

  a_final_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.final_item |=> !in_ready_o)
    else $error("input still taken after final transaction");

endmodule
